/* design/per_source_connect_flood_limiter_macros.svh */
// assertion macros for the connect flood limiter
`ifndef PER_SOURCE_CONNECT_FLOOD_LIMITER_MACROS_SVH
`define PER_SOURCE_CONNECT_FLOOD_LIMITER_MACROS_SVH
`ifndef SYNTHESIS
`define PSCFL_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define PSCFL_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PSCFL_ASSERT_IMP(label, clk, rst_n, a, b)
`define PSCFL_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

/* design/pscfl_pkg.sv */
// shared types and constants of the connect flood limiter
`timescale 1ns / 1ps
package pscfl_pkg;
    localparam int TIME_W    = 48;
    localparam int KEY_W     = 32;
    localparam int MAXC_W    = 4;
    localparam int PERIOD_W  = 32;
    localparam int TRACKED_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [TIME_W:0] SWEEP_INTERVAL = 49'd1000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CONNECTIONS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAN_LENGTH      = 2'd2;

    localparam logic CMD_CONNECT = 1'b0;
    localparam logic CMD_CHECK   = 1'b1;

    typedef struct packed {
        logic              command;
        logic [KEY_W-1:0]  source_key;
        logic [TIME_W-1:0] now;
    } in_item_t;

    typedef struct packed {
        logic                 flooding;
        logic                 table_full;
        logic [TRACKED_W-1:0] tracked_count;
    } out_item_t;

    typedef struct packed {
        logic              sweep;
        logic              apply;
        logic              alloc;
        logic              command;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] thr;
        logic              have_thr;
        logic [TIME_W-1:0] ban_end;
        logic [MAXC_W-1:0] max_conn;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic hit;
        logic free_ok;
    } tok_t;
endpackage

/* design/per_source_connect_flood_limiter.sv */
// Per-source connect flood limiter: a row of entry cells with a shared controller.
// in channel (in_valid/in_ready/in_data) carries command, source key and time;
// out channel (out_valid/out_ready/out_data) returns one result per item:
// flooding, table_full and the number of tracked entries.
// cfg_we/cfg_index/cfg_data write max_connections, sample_period, ban_length
// (indexes 0, 1, 2), one register per write; write only while no item is in flight.
// Each item passes from the input transfer through ST_SEARCH, ST_APPLY and
// ST_RESULT to out_valid; the search token walks the cell row one cell per
// clock. When the periodic sweep runs (1000 ticks after the last one) it comes
// first, in ST_SWEEP, in which every valid, unbanned cell drops at most one
// expired join time per clock.
// One item is worked on at a time; the next input transfer is taken as soon as
// the controller is idle, even while the previous result waits in the output
// register. A stalled receiver holds the result and stalls the next item, and so the input, in ST_RESULT.
// Reset clears all entries, the sweep time and loads the register defaults.
`timescale 1ns / 1ps
module per_source_connect_flood_limiter
    import pscfl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int HISTORY_DEPTH = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
`include "per_source_connect_flood_limiter_macros.svh"

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SC_W  = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SEARCH,
        ST_APPLY,
        ST_RESULT
    } state_t;

    state_t              state_reg;
    logic [MAXC_W-1:0]   max_conn_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] ban_len_reg;
    logic [TIME_W-1:0]   last_sweep_reg;
    in_item_t            item_reg;
    logic [TIME_W-1:0]   thr_reg;
    logic                have_thr_reg;
    logic [TIME_W-1:0]   ban_end_reg;
    logic [SC_W-1:0]     sweep_cnt_reg;
    logic                launch_reg;
    logic                hit_reg;
    logic                free_ok_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;

    logic [TIME_W:0]     sweep_due;
    logic [TIME_W:0]     ban_sum;
    logic [TIME_W:0]     thr_diff;
    cell_ctl_t           ctl;
    tok_t                tok_w [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]    fidx_w [TABLE_ENTRIES+1];
    logic [CNT_W-1:0]    cnt_w [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] flood_w;
    logic                alloc;
    logic [TRACKED_W-1:0] tracked;

    assign sweep_due = {1'b0, last_sweep_reg} + SWEEP_INTERVAL;
    assign ban_sum   = {1'b0, in_data.now} + (TIME_W+1)'(ban_len_reg);
    assign thr_diff  = {1'b0, in_data.now} - (TIME_W+1)'(period_reg);
    assign alloc     = !hit_reg && free_ok_reg;
    assign tracked   = TRACKED_W'(count_reg + CNT_W'(alloc));

    always_comb
    begin
        ctl.sweep    = (state_reg == ST_SWEEP);
        ctl.apply    = (state_reg == ST_APPLY) && (hit_reg || free_ok_reg);
        ctl.alloc    = !hit_reg;
        ctl.command  = item_reg.command;
        ctl.key      = item_reg.source_key;
        ctl.now      = item_reg.now;
        ctl.thr      = thr_reg;
        ctl.have_thr = have_thr_reg;
        ctl.ban_end  = ban_end_reg;
        ctl.max_conn = max_conn_reg;
    end

    assign tok_w[0]  = '{valid: launch_reg, hit: 1'b0, free_ok: 1'b0};
    assign fidx_w[0] = '0;
    assign cnt_w[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        pscfl_cell #(
            .TABLE_ENTRIES(TABLE_ENTRIES),
            .HISTORY_DEPTH(HISTORY_DEPTH),
            .IDX(g)
        ) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .ctl(ctl),
            .sel_idx(free_idx_reg),
            .tok_in(tok_w[g]),
            .free_idx_in(fidx_w[g]),
            .count_in(cnt_w[g]),
            .tok_out(tok_w[g+1]),
            .free_idx_out(fidx_w[g+1]),
            .count_out(cnt_w[g+1]),
            .flood(flood_w[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_conn_reg   <= 4'd5;
            period_reg     <= 32'd1000;
            ban_len_reg    <= 32'd60000;
            last_sweep_reg <= '0;
            sweep_cnt_reg  <= '0;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_CONNECTIONS: max_conn_reg <= cfg_data[MAXC_W-1:0];
                    CFG_SAMPLE_PERIOD:   period_reg   <= cfg_data;
                    CFG_BAN_LENGTH:      ban_len_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_RESULT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if ({1'b0, in_data.now} >= sweep_due)
                        begin
                            last_sweep_reg <= in_data.now;
                            sweep_cnt_reg  <= '0;
                            state_reg      <= ST_SWEEP;
                        end
                        else
                        begin
                            launch_reg <= 1'b1;
                            state_reg  <= ST_SEARCH;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + SC_W'(1);
                    if (sweep_cnt_reg == SC_W'(HISTORY_DEPTH))
                    begin
                        launch_reg <= 1'b1;
                        state_reg  <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    launch_reg <= 1'b0;
                    if (tok_w[TABLE_ENTRIES].valid)
                    begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg     <= in_data;
            have_thr_reg <= !thr_diff[TIME_W];
            thr_reg      <= thr_diff[TIME_W-1:0];
            ban_end_reg  <= ban_sum[TIME_W] ? TIME_MAX : ban_sum[TIME_W-1:0];
        end
        if (state_reg == ST_SEARCH && tok_w[TABLE_ENTRIES].valid)
        begin
            hit_reg      <= tok_w[TABLE_ENTRIES].hit;
            free_ok_reg  <= tok_w[TABLE_ENTRIES].free_ok;
            free_idx_reg <= fidx_w[TABLE_ENTRIES];
            count_reg    <= cnt_w[TABLE_ENTRIES];
        end
        if (state_reg == ST_RESULT && (!out_valid_reg || out_ready))
        begin
            out_reg.flooding      <= (|flood_w) || !(hit_reg || free_ok_reg);
            out_reg.table_full    <= !(hit_reg || free_ok_reg);
            out_reg.tracked_count <= tracked;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PSCFL_ASSERT_IMP(a_tok_in_search, clk, rst_n, tok_w[TABLE_ENTRIES].valid, state_reg == ST_SEARCH)
    `PSCFL_ASSERT_NXT(a_sweep_ends, clk, rst_n, state_reg == ST_SWEEP && sweep_cnt_reg == SC_W'(HISTORY_DEPTH), state_reg == ST_SEARCH && launch_reg)
    `PSCFL_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

/* design/pscfl_cell.sv */
// one table entry with its join history and search token stage
`timescale 1ns / 1ps
module pscfl_cell
    import pscfl_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int HISTORY_DEPTH = 16,
    parameter int IDX = 0
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cell_ctl_t                          ctl,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   sel_idx,
    input  tok_t                               tok_in,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]   free_idx_in,
    input  logic [$clog2(TABLE_ENTRIES+1)-1:0] count_in,
    output tok_t                               tok_out,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   free_idx_out,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0] count_out,
    output logic                               flood
);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int HC_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int HI_W  = $clog2(HISTORY_DEPTH);

    logic                valid_reg, valid_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   ban_reg, ban_next;
    logic [HC_W-1:0]     cnt_reg, cnt_next;
    logic [TIME_W-1:0]   hist_reg [HISTORY_DEPTH];
    logic [TIME_W-1:0]   hist_next [HISTORY_DEPTH];
    logic                flood_reg, flood_next;
    tok_t                tok_reg;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                banned, me_hit, target;
    logic [TIME_W-1:0]   cur_ban;
    logic [HC_W-1:0]     cur_cnt;

    assign banned = ctl.now < ban_reg;
    assign me_hit = valid_reg && (key_reg == ctl.key);
    assign target = ctl.apply && (ctl.alloc ? (sel_idx == IDX_W'(IDX)) : me_hit);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        ban_next   = ban_reg;
        cnt_next   = cnt_reg;
        hist_next  = hist_reg;
        flood_next = ctl.apply ? 1'b0 : flood_reg;
        cur_ban    = ban_reg;
        cur_cnt    = cnt_reg;
        if (ctl.sweep)
        begin
            if (valid_reg && !banned)
            begin
                if (cnt_reg == '0)
                begin
                    valid_next = 1'b0;
                end
                else if (ctl.have_thr && (hist_reg[0] <= ctl.thr))
                begin
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    begin
                        hist_next[i] = hist_reg[i+1];
                    end
                    cnt_next = cnt_reg - HC_W'(1);
                end
            end
        end
        else if (target)
        begin
            if (ctl.alloc)
            begin
                valid_next = 1'b1;
                key_next   = ctl.key;
                ban_next   = '0;
                cnt_next   = '0;
                cur_ban    = '0;
                cur_cnt    = '0;
            end
            if (ctl.now < cur_ban)
            begin
                flood_next = 1'b1;
            end
            else if (32'(cur_cnt) > 32'(ctl.max_conn))
            begin
                ban_next   = ctl.ban_end;
                flood_next = 1'b1;
            end
            else if (ctl.command == CMD_CONNECT)
            begin
                if (cur_cnt == HC_W'(HISTORY_DEPTH))
                begin
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                    begin
                        hist_next[i] = hist_reg[i+1];
                    end
                    hist_next[HISTORY_DEPTH-1] = ctl.now;
                end
                else
                begin
                    hist_next[cur_cnt[HI_W-1:0]] = ctl.now;
                    cnt_next = cur_cnt + HC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ban_reg   <= '0;
            cnt_reg   <= '0;
            flood_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg     <= valid_next;
            ban_reg       <= ban_next;
            cnt_reg       <= cnt_next;
            flood_reg     <= flood_next;
            tok_reg.valid <= tok_in.valid;
            tok_reg.hit   <= tok_in.hit | me_hit;
            tok_reg.free_ok <= tok_in.free_ok | !valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        hist_reg     <= hist_next;
        free_idx_reg <= (tok_in.free_ok || valid_reg) ? free_idx_in : IDX_W'(IDX);
        count_reg    <= count_in + CNT_W'(valid_reg);
    end

    assign tok_out      = tok_reg;
    assign free_idx_out = free_idx_reg;
    assign count_out    = count_reg;
    assign flood        = flood_reg;
endmodule

/* tb/per_source_connect_flood_limiter_tb.sv */
// self-checking testbench for the per-source connect flood limiter
`timescale 1ns / 1ps
module per_source_connect_flood_limiter_tb;
    import pscfl_pkg::*;

    localparam int ENTRIES = 64;
    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 4000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    per_source_connect_flood_limiter dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // limiter state as predicted
    logic [MAXC_W-1:0] lim_max_conn;
    logic [PERIOD_W-1:0] lim_period;
    logic [PERIOD_W-1:0] lim_ban_len;
    logic lim_valid [ENTRIES];
    logic [KEY_W-1:0] lim_key [ENTRIES];
    logic [TIME_W-1:0] lim_ban_end [ENTRIES];
    int lim_count [ENTRIES];
    int lim_head [ENTRIES];
    logic [TIME_W-1:0] lim_times [ENTRIES][DEPTH];
    logic [TIME_W-1:0] lim_last_sweep;

    out_item_t verdict_q[$];
    out_item_t verdict_exp;
    int mismatches;
    int idle_cycles;
    int burst_left;
    int gap_max;
    bit valid_q;
    bit stall_on;
    int ready_phase;
    logic [TIME_W-1:0] clock_now;
    logic [KEY_W-1:0] hot_keys [6];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic out_item_t limiter_predict(logic cmd, logic [KEY_W-1:0] key,
                                                  logic [TIME_W-1:0] t);
        logic have_thr;
        logic [TIME_W-1:0] thr;
        logic [TIME_W:0] ban_sum;
        int e;
        int k;
        int hit;
        int spare;
        int held;
        out_item_t r;
        have_thr = t >= {16'd0, lim_period};
        thr = t - {16'd0, lim_period};
        hit = -1;
        spare = -1;
        held = 0;
        r = '0;
        if ({1'b0, t} >= {1'b0, lim_last_sweep} + SWEEP_INTERVAL)
        begin
            lim_last_sweep = t;
            for (e = 0; e < ENTRIES; e++)
            begin
                if (lim_valid[e] && t >= lim_ban_end[e])
                begin
                    k = 0;
                    while (have_thr && k < lim_count[e]
                           && lim_times[e][(lim_head[e] + k) % DEPTH] <= thr)
                        k++;
                    lim_head[e] = (lim_head[e] + k) % DEPTH;
                    lim_count[e] -= k;
                    if (lim_count[e] == 0)
                        lim_valid[e] = 1'b0;
                end
            end
        end
        for (e = 0; e < ENTRIES; e++)
        begin
            if (lim_valid[e])
            begin
                if (hit < 0 && lim_key[e] == key)
                    hit = e;
            end
            else if (spare < 0)
                spare = e;
        end
        if (hit < 0 && spare >= 0)
        begin
            hit = spare;
            lim_valid[hit] = 1'b1;
            lim_key[hit] = key;
            lim_ban_end[hit] = '0;
            lim_count[hit] = 0;
            lim_head[hit] = 0;
        end
        if (hit < 0)
        begin
            r.flooding = 1'b1;
            r.table_full = 1'b1;
        end
        else if (t < lim_ban_end[hit])
            r.flooding = 1'b1;
        else if (lim_count[hit] > int'(lim_max_conn))
        begin
            ban_sum = {1'b0, t} + {17'd0, lim_ban_len};
            lim_ban_end[hit] = ban_sum[TIME_W] ? TIME_MAX : ban_sum[TIME_W-1:0];
            r.flooding = 1'b1;
        end
        else if (cmd == CMD_CONNECT)
        begin
            if (lim_count[hit] >= DEPTH)
            begin
                lim_times[hit][lim_head[hit]] = t;
                lim_head[hit] = (lim_head[hit] + 1) % DEPTH;
            end
            else
            begin
                lim_times[hit][(lim_head[hit] + lim_count[hit]) % DEPTH] = t;
                lim_count[hit]++;
            end
        end
        for (e = 0; e < ENTRIES; e++)
            if (lim_valid[e])
                held++;
        r.tracked_count = held[TRACKED_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("error at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] t);
        in_valid <= 1'b1;
        in_data <= '{command: cmd, source_key: key, now: t};
        valid_q = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        verdict_q.insert(verdict_q.size(), limiter_predict(cmd, key, t));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && gap_max > 0)
        begin
            in_valid <= 1'b0;
            valid_q = 1'b0;
            repeat (1 + $urandom_range(0, gap_max))
                @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic end_burst();
        if (valid_q)
        begin
            in_valid <= 1'b0;
            valid_q = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        end_burst();
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    task automatic write_regs(input logic [MAXC_W-1:0] maxc, input logic [PERIOD_W-1:0] period,
                              input logic [PERIOD_W-1:0] ban);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_CONNECTIONS;
        cfg_data <= {28'd0, maxc};
        @(posedge clk);
        cfg_index <= CFG_SAMPLE_PERIOD;
        cfg_data <= period;
        @(posedge clk);
        cfg_index <= CFG_BAN_LENGTH;
        cfg_data <= ban;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_max_conn = maxc;
        lim_period = period;
        lim_ban_len = ban;
    endtask

    task automatic test_directed_basics();
        int i;
        send_item(CMD_CONNECT, 32'h0000_0000, 48'd0);
        send_item(CMD_CHECK, 32'hFFFF_FFFF, 48'd0);
        for (i = 1; i <= 6; i++)
            send_item(CMD_CONNECT, 32'h0000_0000, 48'(i));
        send_item(CMD_CHECK, 32'h0000_0000, 48'd7);
        send_item(CMD_CONNECT, 32'h0000_3039, 48'd1500);
        send_item(CMD_CHECK, 32'h0000_0000, 48'd1501);
        drain();
    endtask

    task automatic random_traffic(input int n, input int step_max);
        int i;
        int pick;
        logic [KEY_W-1:0] key;
        logic [TIME_W-1:0] t;
        for (i = 0; i < 6; i++)
            hot_keys[i] = $urandom;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                key = hot_keys[$urandom_range(0, 5)];
            else if (pick < 90)
                key = $urandom;
            else
                key = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
            clock_now += $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                clock_now += $urandom_range(1000, 5000);
            t = clock_now;
            if (pick >= 96)
                t = clock_now - $urandom_range(1, 3000);
            send_item(($urandom_range(0, 3) == 0), key, t);
        end
    endtask

    task automatic test_table_full();
        int i;
        for (i = 0; i < 80; i++)
        begin
            clock_now += $urandom_range(0, 5);
            send_item(1'($urandom_range(0, 1)), $urandom, clock_now);
        end
        random_traffic(40, 50);
    endtask

    task automatic test_random_phases();
        gap_max = 0;
        stall_on = 1'b0;
        write_regs(4'd5, 32'd1000, 32'd60000);
        random_traffic(110, 200);
        drain();
        gap_max = 6;
        stall_on = 1'b1;
        write_regs(4'd0, 32'd0, 32'd0);
        random_traffic(80, 300);
        drain();
        write_regs(4'd15, 32'd5000, 32'd300);
        random_traffic(110, 100);
        drain();
        gap_max = 3;
        write_regs(4'd3, 32'd100000, 32'd1000);
        test_table_full();
        drain();
        gap_max = 10;
        stall_on = 1'b0;
        write_regs(4'($urandom_range(0, 15)), $urandom_range(0, 65535),
                   $urandom_range(0, 1048575));
        random_traffic(110, 150);
        drain();
        stall_on = 1'b1;
        write_regs(4'd15, 32'hFFFF_FFFF, 32'd1);
        random_traffic(100, 400);
        drain();
    endtask

    task automatic test_extreme_times();
        write_regs(4'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_CONNECT, 32'hA5A5_5A5A, TIME_MAX - 48'd3);
        send_item(CMD_CONNECT, 32'hA5A5_5A5A, TIME_MAX - 48'd2);
        send_item(CMD_CHECK, 32'hA5A5_5A5A, TIME_MAX - 48'd1);
        send_item(CMD_CONNECT, 32'hA5A5_5A5A, TIME_MAX);
        send_item(CMD_CONNECT, 32'h5A5A_A5A5, TIME_MAX);
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_phase <= 0;
        end
        else
        begin
            ready_phase <= ready_phase + 1;
            out_ready <= !stall_on || ((ready_phase % 11) >= 4 && $urandom_range(0, 7) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                verdict_exp = verdict_q.pop_front();
                if (out_data.flooding !== verdict_exp.flooding)
                    report_mismatch($sformatf("flooding %b, expected %b",
                                              out_data.flooding, verdict_exp.flooding));
                if (out_data.table_full !== verdict_exp.table_full)
                    report_mismatch($sformatf("table_full %b, expected %b",
                                              out_data.table_full, verdict_exp.table_full));
                if (out_data.tracked_count !== verdict_exp.tracked_count)
                    report_mismatch($sformatf("tracked_count %0d, expected %0d",
                                              out_data.tracked_count, verdict_exp.tracked_count));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int e;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_MAX_CONNECTIONS;
        cfg_data <= '0;
        stall_on = 1'b1;
        gap_max = 4;
        burst_left = 3;
        valid_q = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        lim_max_conn = 4'd5;
        lim_period = 32'd1000;
        lim_ban_len = 32'd60000;
        lim_last_sweep = '0;
        for (e = 0; e < ENTRIES; e++)
        begin
            lim_valid[e] = 1'b0;
            lim_ban_end[e] = '0;
            lim_count[e] = 0;
            lim_head[e] = 0;
        end
        clock_now = 48'd2000 + {8'd0, 8'($urandom), 32'($urandom)};
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_basics();
        test_random_phases();
        test_extreme_times();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
